[rtl/core/itts_pkg.sv]
// ----------------------------------------------------------------------------
// itts_pkg: shared types and constants of the interval task timer scheduler
// Table size, field widths, request kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package itts_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = 4;
	localparam int TIME_W     = 32;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_ENABLE  = 2'd1,
		KIND_DISABLE = 2'd2,
		KIND_UPDATE  = 2'd3
	} itts_kind_t;

	// controller to datapath
	typedef struct packed {
		logic cap;   // capture the accepted request
		logic op;    // execute add, enable or disable and emit its result
		logic step;  // evaluate one table entry of the scan
		logic fin;   // emit the closing result of a scan
	} itts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_update;
		logic scan_done;
		logic hit_report;
		logic pend_valid;
		logic out_free;
	} itts_stat_t;

endpackage

[rtl/core/itts_if.sv]
// ----------------------------------------------------------------------------
// itts_if: request and result channels of the scheduler
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface itts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] now_time;
	logic [2:0]  task_index;
	logic [31:0] interval;
	logic        repeat_req;
	logic        has_action;

	modport source (output valid, kind, now_time, task_index, interval, repeat_req,
		has_action, input ready);
	modport sink (input valid, kind, now_time, task_index, interval, repeat_req,
		has_action, output ready);
endinterface

interface itts_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  result_index;
	logic        fired;
	logic [31:0] run_count;
	logic [3:0]  tasks_in_use;
	logic        last;

	modport source (output valid, ok, result_index, fired, run_count, tasks_in_use,
		last, input ready);
	modport sink (input valid, ok, result_index, fired, run_count, tasks_in_use,
		last, output ready);
endinterface

[rtl/core/itts_ctrl.sv]
// ----------------------------------------------------------------------------
// itts_ctrl: scheduler controller
// Sequences capture, single operations, the entry scan and the closing beat.
// ----------------------------------------------------------------------------
module itts_ctrl
	import itts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  itts_stat_t st,
	output itts_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_SCAN,
		S_FINAL
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd      = '0;
		cmd.cap  = (state_q == S_IDLE) && in_valid;
		cmd.op   = (state_q == S_OP) && !st.is_update && st.out_free;
		// a reporting hit with a pending beat needs room in the output register
		cmd.step = (state_q == S_SCAN) && !st.scan_done &&
			!(st.hit_report && st.pend_valid && !st.out_free);
		cmd.fin  = (state_q == S_FINAL) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_OP;
				end
				S_OP: begin
					if (st.is_update) state_q <= S_SCAN;
					else if (st.out_free) state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (st.scan_done) state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/itts_datapath.sv]
// ----------------------------------------------------------------------------
// itts_datapath: task table, scan logic and result register
// Holds the request, the entry table, one pending fired beat and the output.
// ----------------------------------------------------------------------------
module itts_datapath
	import itts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        kind,
	input  logic [TIME_W-1:0] now_time,
	input  logic [IDX_W-1:0]  task_index,
	input  logic [TIME_W-1:0] interval,
	input  logic              repeat_req,
	input  logic              has_action,
	input  itts_cmd_t         cmd,
	output itts_stat_t        st,
	itts_rsp_if.source        rsp
);

	// captured request
	itts_kind_t        kind_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] ivl_q;
	logic              rep_q;
	logic              act_q;

	// task table
	logic [TIME_W-1:0] period_q    [TASK_SLOTS];
	logic [TIME_W-1:0] last_run_q  [TASK_SLOTS];
	logic [TIME_W-1:0] exec_cnt_q  [TASK_SLOTS];
	logic              en_q        [TASK_SLOTS];
	logic              rep_flag_q  [TASK_SLOTS];
	logic              act_flag_q  [TASK_SLOTS];
	logic [CNT_W-1:0]  used_q;

	// scan state
	logic [CNT_W-1:0]  scan_q;
	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [TIME_W-1:0] pend_cnt_q;

	// result register
	logic              out_valid_q;
	logic              ok_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              fired_q;
	logic [TIME_W-1:0] run_cnt_q;
	logic [CNT_W-1:0]  in_use_q;
	logic              last_q;

	logic [IDX_W-1:0]  addr;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] next_cnt;
	logic              fire;
	logic              out_free;
	logic              not_full;
	logic              idx_used;
	logic              add_go;
	logic              ctl_go;

	always_comb begin
		unique case (kind_q)
			KIND_UPDATE: addr = scan_q[IDX_W-1:0];
			KIND_ADD:    addr = used_q[IDX_W-1:0];
			default:     addr = idx_q;
		endcase
	end

	assign elapsed  = now_q - last_run_q[addr];
	assign fire     = en_q[addr] && (elapsed >= period_q[addr]);
	assign next_cnt = exec_cnt_q[addr] + TIME_W'(1);
	assign out_free = !out_valid_q || rsp.ready;
	assign not_full = (used_q != CNT_W'(TASK_SLOTS));
	assign idx_used = (CNT_W'(idx_q) < used_q);
	assign add_go   = cmd.op && (kind_q == KIND_ADD) && not_full;
	assign ctl_go   = cmd.op && (kind_q != KIND_ADD) && idx_used;

	always_comb begin
		st            = '0;
		st.is_update  = (kind_q == KIND_UPDATE);
		st.scan_done  = (scan_q >= used_q);
		st.hit_report = fire && act_flag_q[addr];
		st.pend_valid = pend_valid_q;
		st.out_free   = out_free;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= itts_kind_t'(kind);
			now_q  <= now_time;
			idx_q  <= task_index;
			ivl_q  <= interval;
			rep_q  <= repeat_req;
			act_q  <= has_action;
		end
	end

	// table entries, written only at addr
	always_ff @(posedge clk) begin
		if (add_go) begin
			period_q[addr]   <= ivl_q;
			last_run_q[addr] <= now_q;
			exec_cnt_q[addr] <= '0;
			en_q[addr]       <= 1'b1;
			rep_flag_q[addr] <= rep_q;
			act_flag_q[addr] <= act_q;
		end else if (ctl_go) begin
			en_q[addr] <= (kind_q == KIND_ENABLE);
			if (kind_q == KIND_ENABLE) last_run_q[addr] <= now_q;
		end else if (cmd.step && fire) begin
			if (act_flag_q[addr]) exec_cnt_q[addr] <= next_cnt;
			if (rep_flag_q[addr]) last_run_q[addr] <= last_run_q[addr] + period_q[addr];
			else en_q[addr] <= 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			scan_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (add_go) used_q <= used_q + CNT_W'(1);
			if (cmd.cap) begin
				scan_q       <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.step) begin
				scan_q <= scan_q + CNT_W'(1);
				if (fire && act_flag_q[addr]) pend_valid_q <= 1'b1;
			end
			if (cmd.fin) pend_valid_q <= 1'b0;
			if (rsp.ready) out_valid_q <= 1'b0;
			if (cmd.op || cmd.fin ||
				(cmd.step && fire && act_flag_q[addr] && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// pending beat and result payload
	always_ff @(posedge clk) begin
		if (cmd.step && fire && act_flag_q[addr]) begin
			pend_idx_q <= addr;
			pend_cnt_q <= next_cnt;
		end
		if (cmd.op) begin
			fired_q   <= 1'b0;
			run_cnt_q <= '0;
			last_q    <= 1'b1;
			if (kind_q == KIND_ADD) begin
				ok_q      <= not_full;
				res_idx_q <= not_full ? addr : '0;
				in_use_q  <= not_full ? used_q + CNT_W'(1) : used_q;
			end else begin
				ok_q      <= idx_used;
				res_idx_q <= idx_q;
				in_use_q  <= used_q;
			end
		end else if (cmd.fin) begin
			ok_q      <= 1'b1;
			res_idx_q <= pend_valid_q ? pend_idx_q : '0;
			fired_q   <= pend_valid_q;
			run_cnt_q <= pend_valid_q ? pend_cnt_q : '0;
			in_use_q  <= used_q;
			last_q    <= 1'b1;
		end else if (cmd.step && fire && act_flag_q[addr] && pend_valid_q) begin
			// push the earlier hit out; it is not the final beat
			ok_q      <= 1'b1;
			res_idx_q <= pend_idx_q;
			fired_q   <= 1'b1;
			run_cnt_q <= pend_cnt_q;
			in_use_q  <= used_q;
			last_q    <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.result_index = res_idx_q;
	assign rsp.fired        = fired_q;
	assign rsp.run_count    = run_cnt_q;
	assign rsp.tasks_in_use = in_use_q;
	assign rsp.last         = last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TASK_SLOTS))
		else $error("entry count beyond table size");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= used_q)
		else $error("scan pointer past used entries");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && fire && act_flag_q[addr] && pend_valid_q |-> out_free)
		else $error("pending beat pushed into a full output register");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !pend_valid_q && out_valid_q && last_q)
		else $error("closing beat did not drain the pending hit");

endmodule

[rtl/core/interval_task_timer_scheduler.sv]
// ----------------------------------------------------------------------------
// interval_task_timer_scheduler: table of interval timers scanned on request
// Top level joining the controller and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: add, enable, disable or update, each
//   with the current 32-bit time. rsp returns result beats; the final beat
//   of a request has last set.
//   Add, enable and disable produce one beat; after acceptance the request
//   waits in the operation state until the output register is free to load it.
//   Update scans the used entries one per cycle, while rsp does not stall,
//   through the table's single read/write address; at most 8 are in use.
//   Each fired task with an action yields a beat; with none, one empty beat.
//   req.ready is high only while no request is in progress. A finished beat
//   waiting in the output register does not block the next request.
//   When rsp stalls, the scan holds at a reporting entry until the previous
//   beat is taken; results are never dropped or reordered.
//   Reset clears the entry count, the output valid and the controller; the
//   table contents need no clearing since only added entries are read.
// ----------------------------------------------------------------------------
module interval_task_timer_scheduler
	import itts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	itts_req_if.sink   req,
	itts_rsp_if.source rsp
);

	itts_cmd_t  cmd;
	itts_stat_t st;
	logic       in_ready;

	assign req.ready = in_ready;

	itts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	itts_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (req.kind),
		.now_time   (req.now_time),
		.task_index (req.task_index),
		.interval   (req.interval),
		.repeat_req (req.repeat_req),
		.has_action (req.has_action),
		.cmd        (cmd),
		.st         (st),
		.rsp        (rsp)
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the interval task timer scheduler
// Sends add, enable, disable and update requests against a moving millisecond
// time, predicts every result beat from a local copy of the task table and
// checks the beats in order, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import itts_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 210;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		itts_kind_t  kind;
		logic [31:0] now_time;
		logic [2:0]  task_index;
		logic [31:0] interval;
		logic        repeat_req;
		logic        has_action;
	} sched_req_t;

	typedef struct {
		logic        ok;
		logic [2:0]  result_index;
		logic        fired;
		logic [31:0] run_count;
		logic [3:0]  tasks_in_use;
		logic        last;
	} sched_beat_t;

	logic clk;
	logic arst_n;

	itts_req_if req_ch();
	itts_rsp_if rsp_ch();

	interval_task_timer_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// task table as the scheduler should hold it
	logic [31:0] tbl_period   [TASK_SLOTS];
	logic [31:0] tbl_last_run [TASK_SLOTS];
	logic [31:0] tbl_runs     [TASK_SLOTS];
	logic        tbl_enabled  [TASK_SLOTS];
	logic        tbl_repeat   [TASK_SLOTS];
	logic        tbl_action   [TASK_SLOTS];
	logic [3:0]  tbl_used;

	sched_beat_t beats_due[$];
	int          mismatches = 0;
	int          cycles = 0;
	logic [31:0] now_ms;
	logic [31:0] long_start;
	bit          steady;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic sched_beat_t make_beat(logic ok, logic [2:0] idx, logic fired,
		logic [31:0] runs, logic last);
		sched_beat_t b;
		b.ok           = ok;
		b.result_index = idx;
		b.fired        = fired;
		b.run_count    = runs;
		b.tasks_in_use = tbl_used;
		b.last         = last;
		return b;
	endfunction

	function automatic void predict_beats(sched_req_t r);
		sched_beat_t scan[$];
		logic [31:0] elapsed;
		logic [2:0]  slot;
		case (r.kind)
			KIND_ADD: begin
				if (tbl_used >= TASK_SLOTS) begin
					beats_due.push_back(make_beat(1'b0, 3'd0, 1'b0, 32'd0, 1'b1));
				end else begin
					slot                = tbl_used[2:0];
					tbl_period[slot]    = r.interval;
					tbl_last_run[slot]  = r.now_time;
					tbl_runs[slot]      = 32'd0;
					tbl_enabled[slot]   = 1'b1;
					tbl_repeat[slot]    = r.repeat_req;
					tbl_action[slot]    = r.has_action;
					tbl_used            = tbl_used + 4'd1;
					beats_due.push_back(make_beat(1'b1, slot, 1'b0, 32'd0, 1'b1));
				end
			end
			KIND_ENABLE, KIND_DISABLE: begin
				if (r.task_index >= tbl_used) begin
					beats_due.push_back(make_beat(1'b0, r.task_index, 1'b0, 32'd0, 1'b1));
				end else begin
					if (r.kind == KIND_ENABLE) begin
						tbl_enabled[r.task_index]  = 1'b1;
						tbl_last_run[r.task_index] = r.now_time;
					end else begin
						tbl_enabled[r.task_index] = 1'b0;
					end
					beats_due.push_back(make_beat(1'b1, r.task_index, 1'b0, 32'd0, 1'b1));
				end
			end
			default: begin
				for (int i = 0; i < tbl_used; i++) begin
					elapsed = r.now_time - tbl_last_run[i];
					if (tbl_enabled[i] && elapsed >= tbl_period[i]) begin
						if (tbl_action[i]) begin
							tbl_runs[i] = tbl_runs[i] + 32'd1;
							scan.push_back(make_beat(1'b1, 3'(i), 1'b1, tbl_runs[i], 1'b0));
						end
						if (tbl_repeat[i])
							tbl_last_run[i] = tbl_last_run[i] + tbl_period[i];
						else
							tbl_enabled[i] = 1'b0;
					end
				end
				if (scan.size() == 0) begin
					beats_due.push_back(make_beat(1'b1, 3'd0, 1'b0, 32'd0, 1'b1));
				end else begin
					scan[scan.size() - 1].last = 1'b1;
					foreach (scan[k])
						beats_due.push_back(scan[k]);
				end
			end
		endcase
	endfunction

	function automatic sched_req_t mk_req(itts_kind_t kind, logic [2:0] idx,
		logic [31:0] ivl, logic rep, logic act);
		sched_req_t r;
		r.kind       = kind;
		r.now_time   = now_ms;
		r.task_index = idx;
		r.interval   = ivl;
		r.repeat_req = rep;
		r.has_action = act;
		return r;
	endfunction

	task automatic send_req(sched_req_t r);
		while (!steady && $urandom_range(0, 99) < 22) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.kind       = r.kind;
		req_ch.now_time   = r.now_time;
		req_ch.task_index = r.task_index;
		req_ch.interval   = r.interval;
		req_ch.repeat_req = r.repeat_req;
		req_ch.has_action = r.has_action;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predict_beats(r);
		@(negedge clk);
	endtask

	// disable, enable and update requests against an empty table
	task automatic test_empty_table;
		send_req(mk_req(KIND_DISABLE, 3'd0, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_ENABLE, 3'd7, '1, 1'b1, 1'b1));
		send_req(mk_req(KIND_UPDATE, 3'd0, 32'd0, 1'b0, 1'b0));
	endtask

	// fill all slots just below the time wrap, then overflow the table
	task automatic test_fill_table;
		logic [31:0] periods [TASK_SLOTS];
		bit   [7:0]  rep_mask;
		bit   [7:0]  act_mask;
		periods  = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd5, 32'd10, 32'd30, 32'd7, 32'd15};
		rep_mask = 8'b1101_0101;
		act_mask = 8'b1101_1011;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (i == 1)
				long_start = now_ms;
			send_req(mk_req(KIND_ADD, 3'(i), periods[i], rep_mask[i], act_mask[i]));
			now_ms += 32'd1;
		end
		send_req(mk_req(KIND_ADD, 3'd7, '1, 1'b1, 1'b1));
	endtask

	// zero period, full-range period, one-shot, silent entries, re-enable
	task automatic test_scan;
		now_ms += 32'd3;
		send_req(mk_req(KIND_UPDATE, 3'd0, 32'd0, 1'b0, 1'b0));
		now_ms = long_start - 32'd1;
		send_req(mk_req(KIND_UPDATE, 3'd0, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_DISABLE, 3'd0, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_UPDATE, 3'd0, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_ENABLE, 3'd0, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_ENABLE, 3'd1, 32'd0, 1'b0, 1'b0));
		send_req(mk_req(KIND_UPDATE, 3'd0, 32'd0, 1'b0, 1'b0));
		now_ms += 32'd40;
		send_req(mk_req(KIND_UPDATE, 3'd7, '1, 1'b1, 1'b1));
		send_req(mk_req(KIND_ENABLE, 3'd7, 32'd0, 1'b0, 1'b0));
	endtask

	task automatic test_random(int count);
		int          pick;
		logic [2:0]  idx;
		logic [31:0] ivl;
		itts_kind_t  kind;
		for (int n = 0; n < count; n++) begin
			steady = (n >= 70 && n < 130);
			// advance time in small steps, jump now and then
			if ($urandom_range(0, 99) < 4)
				now_ms = $urandom;
			else
				now_ms += $urandom_range(0, 12);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				kind = KIND_ADD;
			else if (pick < 25)
				kind = KIND_ENABLE;
			else if (pick < 37)
				kind = KIND_DISABLE;
			else
				kind = KIND_UPDATE;
			idx = 3'($urandom_range(0, 7));
			ivl = $urandom;
			send_req(mk_req(kind, idx, ivl, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 22);

	always @(posedge clk) begin
		sched_beat_t got;
		sched_beat_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.ok           = rsp_ch.ok;
			got.result_index = rsp_ch.result_index;
			got.fired        = rsp_ch.fired;
			got.run_count    = rsp_ch.run_count;
			got.tasks_in_use = rsp_ch.tasks_in_use;
			got.last         = rsp_ch.last;
			if (beats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: ok=%0b idx=%0d fired=%0b runs=%0d used=%0d last=%0b",
						got.ok, got.result_index, got.fired, got.run_count,
						got.tasks_in_use, got.last);
			end else begin
				want = beats_due.pop_front();
				if (got.ok !== want.ok || got.result_index !== want.result_index ||
					got.fired !== want.fired || got.run_count !== want.run_count ||
					got.tasks_in_use !== want.tasks_in_use || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("beat mismatch at cycle %0d", cycles);
						$display("  expected ok=%0b idx=%0d fired=%0b runs=%0d used=%0d last=%0b",
							want.ok, want.result_index, want.fired, want.run_count,
							want.tasks_in_use, want.last);
						$display("  actual   ok=%0b idx=%0d fired=%0b runs=%0d used=%0d last=%0b",
							got.ok, got.result_index, got.fired, got.run_count,
							got.tasks_in_use, got.last);
					end
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		steady            = 1'b0;
		tbl_used          = 4'd0;
		now_ms            = 32'hFFFF_FFF0;
		long_start        = 32'd0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_ADD;
		req_ch.now_time   = 32'd0;
		req_ch.task_index = 3'd0;
		req_ch.interval   = 32'd0;
		req_ch.repeat_req = 1'b0;
		req_ch.has_action = 1'b0;
		rsp_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_fill_table();
		test_scan();
		test_random(RANDOM_ITEMS);

		req_ch.valid = 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
